// ===== design/odq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odq_pkg
// shared constants, types and step functions of the ordered dither quantizer
// ----------------------------------------------------------------------------
package odq_pkg;

  localparam int MAX_MAP_SIDE = 64;
  localparam int STORE_DEPTH  = MAX_MAP_SIDE * MAX_MAP_SIDE;
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int SIDE_W       = $clog2(MAX_MAP_SIDE + 1);
  localparam int ADDR_W       = 5;

  localparam logic [ADDR_W-1:0] REG_LEVELS     = 5'd0;
  localparam logic [ADDR_W-1:0] REG_INPUT_MAX  = 5'd4;
  localparam logic [ADDR_W-1:0] REG_OUTPUT_MAX = 5'd8;
  localparam logic [ADDR_W-1:0] REG_MAP_WIDTH  = 5'd12;
  localparam logic [ADDR_W-1:0] REG_MAP_HEIGHT = 5'd16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic [7:0]        levels;
    logic [7:0]        input_max;
    logic [7:0]        output_max;
    logic [SIDE_W-1:0] map_width;
    logic [SIDE_W-1:0] map_height;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  entry_index;
    logic [7:0]        entry_value;
    logic [7:0]        pixel_value;
    logic [15:0]       column;
    logic [15:0]       row;
    logic [SIDE_W-1:0] col_rem;
    logic [SIDE_W-1:0] row_rem;
  } idx_stage_t;

  typedef struct packed {
    logic             valid;
    logic             op;
    logic [IDX_W-1:0] entry_index;
    logic [7:0]       entry_value;
    logic [7:0]       pixel_value;
    logic [IDX_W-1:0] map_index;
  } idx_beat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] pixel_value;
    logic [7:0] threshold;
  } thr_beat_t;

  // four remainder steps of x mod w, one input bit each
  function automatic logic [SIDE_W-1:0] mod_steps(logic [SIDE_W-1:0] r, logic [3:0] b,
                                                   logic [SIDE_W-1:0] w);
    logic [SIDE_W:0]   t;
    logic [SIDE_W-1:0] x;
    x = r;
    for (int i = 3; i >= 0; i--) begin
      t = {x, b[i]};
      if (t >= {1'b0, w}) t = t - {1'b0, w};
      x = t[SIDE_W-1:0];
    end
    return x;
  endfunction

  // four restoring division steps, returns {quotient bits, remainder}
  function automatic logic [11:0] div_steps(logic [7:0] r, logic [3:0] b, logic [7:0] d);
    logic [8:0] t;
    logic [7:0] x;
    logic [3:0] q;
    x = r;
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      t = {x, b[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        q[i] = 1'b1;
      end
      x = t[7:0];
    end
    return {q, x};
  endfunction

  // four compare and subtract steps against d shifted by hi down to hi-3
  function automatic logic [21:0] fdiv_steps(logic [17:0] r, logic [17:0] d, int hi);
    logic [17:0] x;
    logic [17:0] sd;
    logic [3:0]  q;
    x = r;
    q = '0;
    for (int j = 0; j < 4; j++) begin
      sd = d << (hi - j);
      if (x >= sd) begin
        x = x - sd;
        q[3-j] = 1'b1;
      end
    end
    return {q, x};
  endfunction

endpackage
`default_nettype wire

// ===== design/odq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odq_in_if
// input channel: map load and pixel beats
// ----------------------------------------------------------------------------
interface odq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [11:0] entry_index;
  logic [7:0]  entry_value;
  logic [7:0]  pixel_value;
  logic [15:0] column;
  logic [15:0] row;

  modport source (output valid, op, entry_index, entry_value, pixel_value, column, row,
                  input ready);
  modport sink (input valid, op, entry_index, entry_value, pixel_value, column, row,
                output ready);
endinterface
`default_nettype wire

// ===== design/odq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odq_out_if
// output channel: dithered pixel beats
// ----------------------------------------------------------------------------
interface odq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface
`default_nettype wire

// ===== design/ordered_dither_quantizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_dither_quantizer_top
// ordered dither quantizer with a loadable tiled threshold map
// ----------------------------------------------------------------------------
// A fully pipelined block that takes one beat per clock cycle while the
// output is not stalled and holds up to 14 beats in flight. The pipeline is
// made of the four-stage coordinate modulo, the map address stage, the
// registered map memory read, the product stage, the sixteen-step level
// division that runs four steps per stage, the clamp and rescale stage, and
// the two-stage output division with its output register. Load beats write
// the map in stream order, so a pixel sees every load accepted before it,
// and produce no output beat. The whole pipeline holds when the output beat
// is not taken. Configuration must be written only while no beat is in
// flight; the block itself does not enforce this.
module ordered_dither_quantizer_top import odq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  odq_in_if.sink                 in_ch,
  odq_out_if.source              out_ch
);

  cfg_t       cfg;
  logic       adv;
  idx_stage_t in_beat;
  idx_beat_t  idx_beat;
  thr_beat_t  thr_beat;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    in_beat.op          = in_ch.op;
    in_beat.entry_index = in_ch.entry_index;
    in_beat.entry_value = in_ch.entry_value;
    in_beat.pixel_value = in_ch.pixel_value;
    in_beat.column      = in_ch.column;
    in_beat.row         = in_ch.row;
    in_beat.col_rem     = '0;
    in_beat.row_rem     = '0;
  end

  odq_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  odq_index u_index (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_ch.valid), .in_beat(in_beat),
    .cfg(cfg), .out_beat(idx_beat)
  );

  odq_store u_store (
    .clk(clk), .rst(rst), .adv(adv), .in_beat(idx_beat), .out_beat(thr_beat)
  );

  odq_quant u_quant (
    .clk(clk), .rst(rst), .adv(adv), .in_beat(thr_beat), .cfg(cfg),
    .out_valid(out_ch.valid), .pixel_out(out_ch.pixel_out)
  );

endmodule
`default_nettype wire

// ===== design/odq_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odq_cfg
// apb register file, presents limited working values
// ----------------------------------------------------------------------------
module odq_cfg import odq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [7:0] levels;
  logic [7:0] input_max;
  logic [7:0] output_max;
  logic [6:0] map_width;
  logic [6:0] map_height;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels     <= 8'd1;
      input_max  <= 8'd255;
      output_max <= 8'd255;
      map_width  <= 7'd16;
      map_height <= 7'd16;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_LEVELS:     levels     <= pwdata[7:0];
        REG_INPUT_MAX:  input_max  <= pwdata[7:0];
        REG_OUTPUT_MAX: output_max <= pwdata[7:0];
        REG_MAP_WIDTH:  map_width  <= pwdata[6:0];
        REG_MAP_HEIGHT: map_height <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_LEVELS:     prdata = {24'd0, levels};
      REG_INPUT_MAX:  prdata = {24'd0, input_max};
      REG_OUTPUT_MAX: prdata = {24'd0, output_max};
      REG_MAP_WIDTH:  prdata = {25'd0, map_width};
      REG_MAP_HEIGHT: prdata = {25'd0, map_height};
      default:        prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.levels     = (levels == 8'd0) ? 8'd1 : levels;
    cfg.input_max  = (input_max == 8'd0) ? 8'd1 : input_max;
    cfg.output_max = output_max;
    if (map_width == 7'd0) cfg.map_width = SIDE_W'(1);
    else if (map_width > 7'(MAX_MAP_SIDE)) cfg.map_width = SIDE_W'(MAX_MAP_SIDE);
    else cfg.map_width = SIDE_W'(map_width);
    if (map_height == 7'd0) cfg.map_height = SIDE_W'(1);
    else if (map_height > 7'(MAX_MAP_SIDE)) cfg.map_height = SIDE_W'(MAX_MAP_SIDE);
    else cfg.map_height = SIDE_W'(map_height);
  end

endmodule
`default_nettype wire

// ===== design/odq_index.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odq_index
// pipelined coordinate modulo and map address, four bits per stage
// ----------------------------------------------------------------------------
module odq_index import odq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  adv,
  input  wire logic  in_valid,
  input  idx_stage_t in_beat,
  input  cfg_t       cfg,
  output idx_beat_t  out_beat
);

  idx_stage_t st [0:3];
  idx_stage_t st_next [0:3];
  logic [3:0] vld;
  logic [SIDE_W+SIDE_W-1:0] prod;

  always_comb begin
    st_next[0]         = in_beat;
    st_next[0].col_rem = mod_steps('0, in_beat.column[15:12], cfg.map_width);
    st_next[0].row_rem = mod_steps('0, in_beat.row[15:12], cfg.map_height);
    for (int k = 1; k < 4; k++) begin
      st_next[k]         = st[k-1];
      st_next[k].col_rem = mod_steps(st[k-1].col_rem, st[k-1].column[15-4*k -: 4],
                                     cfg.map_width);
      st_next[k].row_rem = mod_steps(st[k-1].row_rem, st[k-1].row[15-4*k -: 4],
                                     cfg.map_height);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign prod = st[3].row_rem * cfg.map_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld            <= '0;
      out_beat.valid <= 1'b0;
    end else if (adv) begin
      vld                  <= {vld[2:0], in_valid};
      out_beat.valid       <= vld[3];
      out_beat.op          <= st[3].op;
      out_beat.entry_index <= st[3].entry_index;
      out_beat.entry_value <= st[3].entry_value;
      out_beat.pixel_value <= st[3].pixel_value;
      out_beat.map_index   <= IDX_W'(prod + {{SIDE_W{1'b0}}, st[3].col_rem});
    end
  end

endmodule
`default_nettype wire

// ===== design/odq_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odq_store
// threshold map memory, writes and reads in beat order
// ----------------------------------------------------------------------------
module odq_store import odq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  idx_beat_t in_beat,
  output thr_beat_t out_beat
);

  logic [7:0] mem [0:STORE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (adv && in_beat.valid && in_beat.op == OP_LOAD) begin
      mem[in_beat.entry_index] <= in_beat.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else if (adv) begin
      out_beat.valid       <= in_beat.valid && in_beat.op == OP_PIXEL;
      out_beat.threshold   <= mem[in_beat.map_index];
      out_beat.pixel_value <= in_beat.pixel_value;
    end
  end

endmodule
`default_nettype wire

// ===== design/odq_quant.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odq_quant
// level quotient, clamp and output rescale, with the output register
// ----------------------------------------------------------------------------
module odq_quant import odq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  thr_beat_t in_beat,
  input  cfg_t      cfg,
  output logic      out_valid,
  output logic [7:0] pixel_out
);

  logic        vm;
  logic [15:0] vl_m;
  logic [15:0] ti_m;
  logic [3:0]  vd;
  logic [15:0] a_d [0:3];
  logic [7:0]  r_d [0:3];
  logic [15:0] q_d [0:3];
  logic        vc;
  logic [17:0] p_c;
  logic        vf;
  logic [17:0] r_f;
  logic [3:0]  q_f;
  logic [15:0] a0;
  logic [11:0] s0;
  logic [11:0] sk [1:3];
  logic [7:0]  lvl;
  logic [15:0] lo;
  logic [21:0] f0;
  logic [21:0] f1;
  logic [17:0] dd;

  assign a0 = vl_m + {8'd0, ti_m[15:8]};
  assign s0 = div_steps(8'd0, a0[15:12], cfg.input_max);
  always_comb begin
    for (int k = 1; k < 4; k++) begin
      sk[k] = div_steps(r_d[k-1], a_d[k-1][15-4*k -: 4], cfg.input_max);
    end
  end

  assign lvl = (q_d[3] > {8'd0, cfg.levels}) ? cfg.levels : q_d[3][7:0];
  assign lo  = lvl * cfg.output_max;
  assign dd  = {9'd0, cfg.levels, 1'b0};
  assign f0  = fdiv_steps(p_c, dd, 7);
  assign f1  = fdiv_steps(r_f, dd, 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= 1'b0;
      vd        <= '0;
      vc        <= 1'b0;
      vf        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vm        <= in_beat.valid;
      vd        <= {vd[2:0], vm};
      vc        <= vd[3];
      vf        <= vc;
      out_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vl_m   <= in_beat.pixel_value * cfg.levels;
      ti_m   <= in_beat.threshold * cfg.input_max;
      a_d[0] <= a0;
      r_d[0] <= s0[7:0];
      q_d[0] <= {s0[11:8], 12'd0};
      for (int k = 1; k < 4; k++) begin
        a_d[k] <= a_d[k-1];
        r_d[k] <= sk[k][7:0];
        q_d[k] <= q_d[k-1] | (16'(sk[k][11:8]) << (12 - 4*k));
      end
      p_c       <= {1'b0, lo, 1'b0} + {10'd0, cfg.levels};
      r_f       <= f0[17:0];
      q_f       <= f0[21:18];
      pixel_out <= {q_f, f1[21:18]};
    end
  end

endmodule
`default_nettype wire

// ===== tb/ordered_dither_quantizer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_dither_quantizer_top_tb
// self-checking testbench of the ordered dither quantizer: map loads and
// pixel beats go in with random gaps, and output stalls are random. A
// scoreboard predicts every pixel from its own copy of the map and the
// registers. The registers are written over APB between phases while the
// block is idle.
// ----------------------------------------------------------------------------
module ordered_dither_quantizer_top_tb;
  import odq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 30;

  typedef struct {
    logic        op;
    logic [11:0] entry_index;
    logic [7:0]  entry_value;
    logic [7:0]  pixel_value;
    logic [15:0] column;
    logic [15:0] row;
  } beat_t;

  class dither_scoreboard;
    logic [7:0]  thresholds [STORE_DEPTH];
    bit          loaded     [STORE_DEPTH];
    logic [7:0]  levels, input_max, output_max;
    logic [6:0]  map_width, map_height;
    logic [7:0]  pixels_due [$];

    function void clear();
      foreach (loaded[i]) loaded[i] = 1'b0;
      levels = 8'd1;
      input_max = 8'd255;
      output_max = 8'd255;
      map_width = 7'd16;
      map_height = 7'd16;
      pixels_due.delete();
    endfunction

    function int unsigned side(logic [6:0] s);
      if (s == 0) return 1;
      if (s > MAX_MAP_SIDE) return MAX_MAP_SIDE;
      return s;
    endfunction

    function int unsigned map_index(logic [15:0] col, logic [15:0] row);
      int unsigned w, h;
      w = side(map_width);
      h = side(map_height);
      return (col % w) + (row % h) * w;
    endfunction

    function logic [7:0] dither(logic [7:0] v, logic [15:0] col, logic [15:0] row);
      longint lv, im, t, num, den, lvl;
      lv = (levels == 0) ? 1 : levels;
      im = (input_max == 0) ? 1 : input_max;
      t = thresholds[map_index(col, row)];
      num = longint'(v) * lv * 256 + (t - 128) * im;
      den = 256 * im;
      lvl = (num < 0) ? 0 : (2 * num + den) / (2 * den);
      if (lvl > lv) lvl = lv;
      return 8'((2 * lvl * output_max + lv) / (2 * lv));
    endfunction

    function void note_beat(beat_t b);
      if (b.op == OP_LOAD) begin
        thresholds[b.entry_index] = b.entry_value;
        loaded[b.entry_index] = 1'b1;
      end else begin
        pixels_due.push_back(dither(b.pixel_value, b.column, b.row));
      end
    endfunction

    function bit check_pixel(logic [7:0] got, output string why);
      logic [7:0] want;
      if (pixels_due.size() == 0) begin
        why = $sformatf("pixel_out %0d with nothing expected", got);
        return 1'b0;
      end
      want = pixels_due.pop_front();
      why = $sformatf("pixel_out %0d, expected %0d", got, want);
      return got === want;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  odq_in_if  in_ch();
  odq_out_if out_ch();

  ordered_dither_quantizer_top dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  dither_scoreboard pixel_board = new();
  int mismatches = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  task automatic report_mismatch(string why);
    $display("[%0t] mismatch: %s", $realtime, why);
    mismatches++;
  endtask

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // output side: check and random backpressure
  always @(posedge clk) begin
    string why;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (!pixel_board.check_pixel(out_ch.pixel_out, why)) report_mismatch(why);
    end
    if ($urandom_range(0, 199) == 0) calm <= ~calm;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(beat_t b);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.op <= b.op;
    in_ch.entry_index <= b.entry_index;
    in_ch.entry_value <= b.entry_value;
    in_ch.pixel_value <= b.pixel_value;
    in_ch.column <= b.column;
    in_ch.row <= b.row;
    do @(posedge clk); while (!in_ch.ready);
    pixel_board.note_beat(b);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_load(int unsigned index, logic [7:0] value);
    beat_t b;
    b.op = OP_LOAD;
    b.entry_index = 12'(index);
    b.entry_value = value;
    b.pixel_value = 8'($urandom);
    b.column = 16'($urandom);
    b.row = 16'($urandom);
    send_beat(b);
  endtask

  // loads the map entry first when it was never written
  task automatic send_pixel(logic [7:0] value, logic [15:0] col, logic [15:0] row);
    beat_t b;
    int unsigned idx;
    idx = pixel_board.map_index(col, row);
    if (!pixel_board.loaded[idx]) send_load(idx, 8'($urandom));
    b.op = OP_PIXEL;
    b.entry_index = 12'($urandom);
    b.entry_value = 8'($urandom);
    b.pixel_value = value;
    b.column = col;
    b.row = row;
    send_beat(b);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pixel_board.pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] lv, logic [7:0] im, logic [7:0] om,
                            logic [6:0] w, logic [6:0] h);
    wait_idle();
    write_reg(REG_LEVELS, lv);
    write_reg(REG_INPUT_MAX, im);
    write_reg(REG_OUTPUT_MAX, om);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    pixel_board.levels = lv;
    pixel_board.input_max = im;
    pixel_board.output_max = om;
    pixel_board.map_width = w;
    pixel_board.map_height = h;
  endtask

  task automatic random_phase(int count);
    repeat (count) begin
      if ($urandom_range(0, 9) < 3) send_load($urandom_range(0, STORE_DEPTH - 1), 8'($urandom));
      else send_pixel(8'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.pixel_value = '0;
    in_ch.column = '0;
    in_ch.row = '0;
    out_ch.ready = 1'b0;
    pixel_board.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default registers, extreme thresholds and samples
    send_load(0, 8'd0);
    send_load(STORE_DEPTH - 1, 8'd255);
    send_pixel(8'd0, 16'd0, 16'd0);
    send_pixel(8'd255, 16'd0, 16'd0);
    send_pixel(8'd128, 16'd0, 16'd0);
    send_load(255, 8'd255);
    send_pixel(8'd255, 16'hFFFF, 16'hFFFF);
    send_pixel(8'd0, 16'hFFFF, 16'hFFFF);
    send_load(17, 8'd128);
    send_pixel(8'd127, 16'd1, 16'd1);
    send_pixel(8'd128, 16'd17, 16'd33);
    send_load(17, 8'd127);
    send_pixel(8'd128, 16'd1, 16'd1);
    // zero levels, zero input_max, zero output_max, zero map sides
    set_config(8'd0, 8'd0, 8'd0, 7'd0, 7'd0);
    send_pixel(8'd0, 16'd5, 16'd9);
    send_pixel(8'd255, 16'hFFFF, 16'd0);
    // map sides above the maximum saturate
    set_config(8'd255, 8'd255, 8'd255, 7'd127, 7'd127);
    send_pixel(8'd255, 16'd63, 16'd63);
    send_pixel(8'd1, 16'hFFFF, 16'h0040);
    random_phase(70);
    set_config(8'd255, 8'd1, 8'd255, 7'd1, 7'd64);
    random_phase(60);
    set_config(8'd1, 8'd255, 8'd0, 7'd64, 7'd1);
    random_phase(60);
    set_config(8'd3, 8'd200, 8'd170, 7'd8, 7'd8);
    random_phase(60);
    repeat (3) begin
      set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)));
      random_phase(55);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/odq_pkg.sv
design/odq_in_if.sv
design/odq_out_if.sv
design/odq_cfg.sv
design/odq_index.sv
design/odq_store.sv
design/odq_quant.sv
design/ordered_dither_quantizer_top.sv
tb/ordered_dither_quantizer_top_tb.sv
